/* src/shp3_pkg.sv */
// shared types, constants and the per-channel kernel for the 3x3 rgb sharpen block
package shp3_pkg;

    localparam int DEF_MAX_WIDTH = 1024;

    localparam int CHAN_W         = 8;
    localparam int FRAME_WIDTH_W  = 11;
    localparam int FRAME_HEIGHT_W = 16;
    localparam int CFG_W          = 16;
    localparam int CFG_IDX_W      = 2;

    localparam logic [FRAME_WIDTH_W-1:0]  RESET_FRAME_WIDTH  = FRAME_WIDTH_W'(640);
    localparam logic [FRAME_HEIGHT_W-1:0] RESET_FRAME_HEIGHT = FRAME_HEIGHT_W'(480);

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // window column picked for each tap column
    localparam logic [1:0] COL_LEFT  = 2'd0;
    localparam logic [1:0] COL_MID   = 2'd1;
    localparam logic [1:0] COL_RIGHT = 2'd2;

    localparam int KERNEL_GAIN = 9;
    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_rgb;

    // one window column, index 0 is the top row
    typedef t_rgb [2:0] t_wcol;
    // whole window, index 0 is the left column
    typedef t_wcol [2:0] t_win;

    // what the datapath does with one word
    typedef struct packed {
        logic            pixel;      // shift in a pixel column and write the line stores
        logic            drain_row;  // last-row flush: shift in a column read from the stores
        logic            first;      // first column of the last-row flush
        logic            top_upper;  // top row of store columns comes from the upper store
        logic            emit;       // word produces a result
        logic            top_clamp;  // replicate the middle row into the top row
        logic            eof;
        logic [2:0][1:0] col_sel;    // window column for the left, centre and right taps
    } t_op;

    // nine times the centre minus the eight neighbours, clamped to a byte
    function automatic logic [CHAN_W-1:0] f_sharpen(input logic [8:0][CHAN_W-1:0] taps);
        logic [11:0]        ctr;
        logic [10:0]        nsum;
        logic signed [12:0] acc;
        logic [CHAN_W-1:0]  res;
        ctr  = 12'(taps[4]) * 12'(KERNEL_GAIN);
        nsum = '0;
        for (int i = 0; i < 9; i++) begin
            if (i != 4) begin
                nsum = nsum + 11'(taps[i]);
            end
        end
        acc = $signed({1'b0, ctr}) - $signed({2'b00, nsum});
        if (acc < 0) begin
            res = '0;
        end else if (acc > $signed(13'(CHAN_MAX))) begin
            res = CHAN_MAX;
        end else begin
            res = acc[CHAN_W-1:0];
        end
        return res;
    endfunction

endpackage

/* src/shp3_ctrl.sv */
// frame registers, position counters and the per-word decision of the sharpen block
module shp3_ctrl #(
    parameter int MAX_WIDTH = shp3_pkg::DEF_MAX_WIDTH,
    parameter int COL_BITS  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [shp3_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [shp3_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_accept,
    input  logic                           i_cmd,
    output shp3_pkg::t_op                  o_op,
    output logic [COL_BITS-1:0]            o_addr_a,
    output logic [COL_BITS-1:0]            o_addr_b
);
    import shp3_pkg::*;

    localparam int W_BITS = $clog2(MAX_WIDTH + 1);

    logic [FRAME_WIDTH_W-1:0]  r_frame_width;
    logic [FRAME_HEIGHT_W-1:0] r_frame_height;
    logic [COL_BITS-1:0]       r_in_col, n_in_col;
    logic [COL_BITS-1:0]       r_out_col, n_out_col;
    logic [FRAME_HEIGHT_W-1:0] r_in_row, n_in_row;
    logic [FRAME_HEIGHT_W-1:0] r_out_row, n_out_row;

    logic [W_BITS-1:0]         eff_w;
    logic [COL_BITS-1:0]       last_col;
    logic                      width_one;
    logic [FRAME_HEIGHT_W-1:0] eff_h;
    logic [FRAME_HEIGHT_W-1:0] last_row;
    logic                      frame_done;
    logic [COL_BITS-1:0]       x, oc;
    logic [FRAME_HEIGHT_W-1:0] y, orow;

    always_comb begin
        if (r_frame_width == '0) begin
            eff_w = W_BITS'(1);
        end else if (32'(r_frame_width) > MAX_WIDTH) begin
            eff_w = W_BITS'(MAX_WIDTH);
        end else begin
            eff_w = W_BITS'(r_frame_width);
        end
        last_col  = COL_BITS'(eff_w - W_BITS'(1));
        width_one = (eff_w == W_BITS'(1));
        eff_h     = (r_frame_height == '0) ? FRAME_HEIGHT_W'(1) : r_frame_height;
        last_row  = eff_h - FRAME_HEIGHT_W'(1);
    end

    assign frame_done = (r_in_row >= eff_h);

    always_comb begin
        // a pixel after a finished frame starts the next one from the top
        if (i_cmd == CMD_PIXEL && frame_done) begin
            x    = '0;
            y    = '0;
            oc   = '0;
            orow = '0;
        end else begin
            x    = r_in_col;
            y    = r_in_row;
            oc   = r_out_col;
            orow = r_out_row;
        end

        o_op      = '0;
        o_addr_a  = x;
        o_addr_b  = x;
        n_in_col  = x;
        n_in_row  = y;
        n_out_col = oc;
        n_out_row = orow;

        if (i_cmd == CMD_PIXEL) begin
            o_op.pixel     = 1'b1;
            o_op.top_clamp = (orow == '0);
            if (x == '0) begin
                // right-edge pixel of the row two above
                o_op.emit       = (y >= FRAME_HEIGHT_W'(2));
                o_op.col_sel[0] = width_one ? COL_MID : COL_LEFT;
                o_op.col_sel[1] = COL_MID;
                o_op.col_sel[2] = COL_MID;
            end else begin
                o_op.emit       = (y >= FRAME_HEIGHT_W'(1));
                o_op.col_sel[0] = (x == COL_BITS'(1)) ? COL_MID : COL_LEFT;
                o_op.col_sel[1] = COL_MID;
                o_op.col_sel[2] = COL_RIGHT;
            end
            if (x == last_col) begin
                n_in_col = '0;
                n_in_row = y + FRAME_HEIGHT_W'(1);
            end else begin
                n_in_col = x + COL_BITS'(1);
            end
        end else if (frame_done && r_out_row < eff_h) begin
            o_op.emit = 1'b1;
            if (orow == last_row) begin
                // bottom row: columns come straight from the line stores
                o_op.drain_row  = 1'b1;
                o_op.first      = (oc == '0);
                o_op.top_upper  = (orow != '0);
                o_op.col_sel[0] = COL_LEFT;
                o_op.col_sel[1] = COL_MID;
                o_op.col_sel[2] = COL_RIGHT;
                o_addr_a        = (oc == last_col) ? oc : oc + COL_BITS'(1);
                o_addr_b        = oc;
            end else begin
                o_op.top_clamp  = (orow == '0);
                o_op.col_sel[0] = width_one ? COL_RIGHT : COL_MID;
                o_op.col_sel[1] = COL_RIGHT;
                o_op.col_sel[2] = COL_RIGHT;
            end
        end

        if (o_op.emit) begin
            o_op.eof = (oc == last_col) && (orow == last_row);
            if (oc == last_col) begin
                n_out_col = '0;
                n_out_row = orow + FRAME_HEIGHT_W'(1);
            end else begin
                n_out_col = oc + COL_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RESET_FRAME_WIDTH;
            r_frame_height <= RESET_FRAME_HEIGHT;
            r_in_col       <= '0;
            r_in_row       <= '0;
            r_out_col      <= '0;
            r_out_row      <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH: begin
                    r_frame_width <= i_cfg_data[FRAME_WIDTH_W-1:0];
                    r_in_col      <= '0;
                    r_in_row      <= '0;
                    r_out_col     <= '0;
                    r_out_row     <= '0;
                end
                CFG_FRAME_HEIGHT: begin
                    r_frame_height <= i_cfg_data[FRAME_HEIGHT_W-1:0];
                    r_in_col       <= '0;
                    r_in_row       <= '0;
                    r_out_col      <= '0;
                    r_out_row      <= '0;
                end
                default: begin
                end
            endcase
        end else if (i_accept) begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

endmodule

/* src/shp3_lines.sv */
// upper and middle line stores, two registered read ports each with write bypass
module shp3_lines #(
    parameter int DEPTH    = shp3_pkg::DEF_MAX_WIDTH,
    parameter int COL_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                i_clk,
    input  logic                i_rd_en,
    input  logic [COL_BITS-1:0] i_rd_addr_a,
    input  logic [COL_BITS-1:0] i_rd_addr_b,
    input  logic                i_wr_en,
    input  logic [COL_BITS-1:0] i_wr_addr,
    input  shp3_pkg::t_rgb      i_wr_upper,
    input  shp3_pkg::t_rgb      i_wr_middle,
    output shp3_pkg::t_rgb      o_upper_a,
    output shp3_pkg::t_rgb      o_middle_a,
    output shp3_pkg::t_rgb      o_upper_b,
    output shp3_pkg::t_rgb      o_middle_b
);
    import shp3_pkg::*;

    t_rgb r_upper  [DEPTH];
    t_rgb r_middle [DEPTH];
    t_rgb r_rd_upper_a, r_rd_middle_a, r_rd_upper_b, r_rd_middle_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_upper[i_wr_addr]  <= i_wr_upper;
            r_middle[i_wr_addr] <= i_wr_middle;
        end
        if (i_rd_en) begin
            // a column being written this cycle is taken from the write data
            if (i_wr_en && i_wr_addr == i_rd_addr_a) begin
                r_rd_upper_a  <= i_wr_upper;
                r_rd_middle_a <= i_wr_middle;
            end else begin
                r_rd_upper_a  <= r_upper[i_rd_addr_a];
                r_rd_middle_a <= r_middle[i_rd_addr_a];
            end
            if (i_wr_en && i_wr_addr == i_rd_addr_b) begin
                r_rd_upper_b  <= i_wr_upper;
                r_rd_middle_b <= i_wr_middle;
            end else begin
                r_rd_upper_b  <= r_upper[i_rd_addr_b];
                r_rd_middle_b <= r_middle[i_rd_addr_b];
            end
        end
    end

    assign o_upper_a  = r_rd_upper_a;
    assign o_middle_a = r_rd_middle_a;
    assign o_upper_b  = r_rd_upper_b;
    assign o_middle_b = r_rd_middle_b;

endmodule

/* src/shp3_window.sv */
// 3x3 window registers, tap selection with edge replication and the sharpen kernel
module shp3_window (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  shp3_pkg::t_op  i_op,
    input  shp3_pkg::t_rgb i_pix,
    input  shp3_pkg::t_rgb i_upper_a,
    input  shp3_pkg::t_rgb i_middle_a,
    input  shp3_pkg::t_rgb i_upper_b,
    input  shp3_pkg::t_rgb i_middle_b,
    output shp3_pkg::t_rgb o_result
);
    import shp3_pkg::*;

    t_win  r_win, n_win;
    t_wcol store_col_a, store_col_b;
    t_win  tap_cols;
    logic [8:0][CHAN_W-1:0] taps_r, taps_g, taps_b;

    always_comb begin
        store_col_a[0] = i_op.top_upper ? i_upper_a : i_middle_a;
        store_col_a[1] = i_middle_a;
        store_col_a[2] = i_middle_a;
        store_col_b[0] = i_op.top_upper ? i_upper_b : i_middle_b;
        store_col_b[1] = i_middle_b;
        store_col_b[2] = i_middle_b;

        n_win = r_win;
        if (i_op.pixel) begin
            n_win[0]    = r_win[1];
            n_win[1]    = r_win[2];
            n_win[2][0] = i_upper_a;
            n_win[2][1] = i_middle_a;
            n_win[2][2] = i_pix;
        end else if (i_op.drain_row) begin
            n_win[0] = i_op.first ? store_col_b : r_win[1];
            n_win[1] = i_op.first ? store_col_b : r_win[2];
            n_win[2] = store_col_a;
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            case (i_op.col_sel[c])
                COL_LEFT:  tap_cols[c] = n_win[0];
                COL_MID:   tap_cols[c] = n_win[1];
                default:   tap_cols[c] = n_win[2];
            endcase
        end
        for (int c = 0; c < 3; c++) begin
            taps_r[c]     = i_op.top_clamp ? tap_cols[c][1].red   : tap_cols[c][0].red;
            taps_g[c]     = i_op.top_clamp ? tap_cols[c][1].green : tap_cols[c][0].green;
            taps_b[c]     = i_op.top_clamp ? tap_cols[c][1].blue  : tap_cols[c][0].blue;
            taps_r[3 + c] = tap_cols[c][1].red;
            taps_g[3 + c] = tap_cols[c][1].green;
            taps_b[3 + c] = tap_cols[c][1].blue;
            taps_r[6 + c] = tap_cols[c][2].red;
            taps_g[6 + c] = tap_cols[c][2].green;
            taps_b[6 + c] = tap_cols[c][2].blue;
        end
        o_result.red   = f_sharpen(taps_r);
        o_result.green = f_sharpen(taps_g);
        o_result.blue  = f_sharpen(taps_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (i_adv) begin
            r_win <= n_win;
        end
    end

endmodule

/* src/sharpen_3x3_rgb_unit.sv */
// top level of the streaming 3x3 laplacian sharpen for rgb pixels
// Takes one word per clock and returns one result per clock while neither side stalls: a word is registered together
// with its line-store columns; then, once the output can take the result, the window shifts and the kernel result is
// registered at the output.
// Each sharpened pixel trails the input by one row plus one pixel; once the frame's last pixel
// is in, drain words flush the remaining results, one each. Two line stores of MAX_WIDTH
// 24-bit entries, each with two registered read ports, hold the previous two rows; they need
// no clearing after reset. A write to either frame register restarts the stream.
module sharpen_3x3_rgb_unit #(
    parameter int MAX_WIDTH = shp3_pkg::DEF_MAX_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [shp3_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [shp3_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_cmd,
    input  logic [shp3_pkg::CHAN_W-1:0]    i_red,
    input  logic [shp3_pkg::CHAN_W-1:0]    i_green,
    input  logic [shp3_pkg::CHAN_W-1:0]    i_blue,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [shp3_pkg::CHAN_W-1:0]    o_red_out,
    output logic [shp3_pkg::CHAN_W-1:0]    o_green_out,
    output logic [shp3_pkg::CHAN_W-1:0]    o_blue_out,
    output logic                           o_end_of_frame
);
    import shp3_pkg::*;

    localparam int COL_BITS = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    t_op                 s0_op;
    logic [COL_BITS-1:0] s0_addr_a, s0_addr_b;
    logic                accept;

    logic                r_s1_valid;
    t_op                 r_s1_op;
    t_rgb                r_s1_pix;
    logic [COL_BITS-1:0] r_s1_addr;
    logic                s1_adv;
    logic                s1_wr;

    logic                r_out_valid;
    t_rgb                r_out_rgb;
    logic                r_out_eof;
    logic                out_free;

    t_rgb upper_a, middle_a, upper_b, middle_b;
    t_rgb result;

    assign out_free = !r_out_valid || !i_stall;
    assign s1_adv   = r_s1_valid && (!r_s1_op.emit || out_free);
    assign o_stall  = r_s1_valid && !s1_adv;
    assign accept   = i_valid && !o_stall;
    assign s1_wr    = s1_adv && r_s1_op.pixel;

    shp3_ctrl #(
        .MAX_WIDTH (MAX_WIDTH),
        .COL_BITS  (COL_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_cmd       (i_cmd),
        .o_op        (s0_op),
        .o_addr_a    (s0_addr_a),
        .o_addr_b    (s0_addr_b)
    );

    shp3_lines #(
        .DEPTH    (MAX_WIDTH),
        .COL_BITS (COL_BITS)
    ) u_lines (
        .i_clk       (i_clk),
        .i_rd_en     (accept),
        .i_rd_addr_a (s0_addr_a),
        .i_rd_addr_b (s0_addr_b),
        .i_wr_en     (s1_wr),
        .i_wr_addr   (r_s1_addr),
        .i_wr_upper  (middle_a),
        .i_wr_middle (r_s1_pix),
        .o_upper_a   (upper_a),
        .o_middle_a  (middle_a),
        .o_upper_b   (upper_b),
        .o_middle_b  (middle_b)
    );

    shp3_window u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (s1_adv),
        .i_op       (r_s1_op),
        .i_pix      (r_s1_pix),
        .i_upper_a  (upper_a),
        .i_middle_a (middle_a),
        .i_upper_b  (upper_b),
        .i_middle_b (middle_b),
        .o_result   (result)
    );

    // word stage: drains that do nothing are taken and dropped here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= s0_op.pixel || s0_op.emit;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_op        <= s0_op;
            r_s1_pix.red   <= i_red;
            r_s1_pix.green <= i_green;
            r_s1_pix.blue  <= i_blue;
            r_s1_addr      <= s0_addr_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && r_s1_op.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_op.emit) begin
            r_out_rgb <= result;
            r_out_eof <= r_s1_op.eof;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_red_out      = r_out_rgb.red;
    assign o_green_out    = r_out_rgb.green;
    assign o_blue_out     = r_out_rgb.blue;
    assign o_end_of_frame = r_out_eof;

endmodule

/* verif/sharpen_checker.sv */
// checker for the 3x3 rgb sharpen: follows both channels, predicts every sharpened pixel, compares
`timescale 1ns / 1ps
module sharpen_checker #(
    parameter int MAX_WIDTH = shp3_pkg::DEF_MAX_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [shp3_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [shp3_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic                           i_cmd,
    input  logic [shp3_pkg::CHAN_W-1:0]    i_red,
    input  logic [shp3_pkg::CHAN_W-1:0]    i_green,
    input  logic [shp3_pkg::CHAN_W-1:0]    i_blue,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic [shp3_pkg::CHAN_W-1:0]    i_red_out,
    input  logic [shp3_pkg::CHAN_W-1:0]    i_green_out,
    input  logic [shp3_pkg::CHAN_W-1:0]    i_blue_out,
    input  logic                           i_end_of_frame,
    input  logic                           i_done,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_checked
);

    typedef struct packed {
        logic [shp3_pkg::CHAN_W-1:0] red;
        logic [shp3_pkg::CHAN_W-1:0] green;
        logic [shp3_pkg::CHAN_W-1:0] blue;
        logic                        eof;
    } t_sharp_px;

    // nine taps, row-major, index 0 is top left
    typedef shp3_pkg::t_rgb [8:0] t_tap_set;

    typedef enum int {CH_RED, CH_GREEN, CH_BLUE} t_chan;

    shp3_pkg::t_rgb line_upper  [MAX_WIDTH];
    shp3_pkg::t_rgb line_middle [MAX_WIDTH];
    // column k, row r at k*3+r, row 0 is the top
    shp3_pkg::t_rgb win [9];

    int unsigned in_col, in_row, out_col, out_row;
    logic [shp3_pkg::FRAME_WIDTH_W-1:0]  frame_w;
    logic [shp3_pkg::FRAME_HEIGHT_W-1:0] frame_h;

    t_sharp_px sharp_q [$];
    bit        done_seen;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        done_seen    = 1'b0;
    end

    task automatic flag_error(input string msg);
        o_fail_count++;
        if (o_fail_count <= 40) begin
            $display("ERROR @%0t: %s", $time, msg);
        end
    endtask

    function automatic int unsigned active_width();
        int unsigned w;
        w = 32'(frame_w);
        if (w < 1) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return w;
    endfunction

    function automatic int unsigned active_height();
        return (frame_h == '0) ? 1 : int'(frame_h);
    endfunction

    function automatic logic [shp3_pkg::CHAN_W-1:0] kernel_chan(input t_tap_set taps,
                                                              input t_chan sel);
        int acc;
        int v;
        int i;
        acc = 0;
        for (i = 0; i < 9; i++) begin
            case (sel)
                CH_RED:   v = int'(taps[i].red);
                CH_GREEN: v = int'(taps[i].green);
                default:  v = int'(taps[i].blue);
            endcase
            if (i == 4) acc += shp3_pkg::KERNEL_GAIN * v;
            else acc -= v;
        end
        if (acc < 0) acc = 0;
        if (acc > int'(shp3_pkg::CHAN_MAX)) acc = int'(shp3_pkg::CHAN_MAX);
        return acc[shp3_pkg::CHAN_W-1:0];
    endfunction

    function automatic t_tap_set window_taps(input logic [1:0] lc, input logic [1:0] cc,
                                             input logic [1:0] rc, input bit top_clamp);
        t_tap_set t;
        int base;
        int k;
        for (k = 0; k < 3; k++) begin
            case (k)
                0:       base = int'(lc) * 3;
                1:       base = int'(cc) * 3;
                default: base = int'(rc) * 3;
            endcase
            t[k]     = win[base + (top_clamp ? 1 : 0)];
            t[3 + k] = win[base + 1];
            t[6 + k] = win[base + 2];
        end
        return t;
    endfunction

    function automatic void push_sharp(input t_tap_set t, input int unsigned w,
                                       input int unsigned h);
        t_sharp_px px;
        px.red   = kernel_chan(t, CH_RED);
        px.green = kernel_chan(t, CH_GREEN);
        px.blue  = kernel_chan(t, CH_BLUE);
        px.eof   = (out_col == w - 1) && (out_row == h - 1);
        sharp_q.push_back(px);
        out_col++;
        if (out_col >= w) begin
            out_col = 0;
            out_row++;
        end
    endfunction

    function automatic void restart_stream();
        in_col  = 0;
        in_row  = 0;
        out_col = 0;
        out_row = 0;
    endfunction

    function automatic void clear_model();
        int i;
        for (i = 0; i < MAX_WIDTH; i++) begin
            line_upper[i]  = '0;
            line_middle[i] = '0;
        end
        for (i = 0; i < 9; i++) win[i] = '0;
        restart_stream();
        frame_w = shp3_pkg::RESET_FRAME_WIDTH;
        frame_h = shp3_pkg::RESET_FRAME_HEIGHT;
        sharp_q.delete();
    endfunction

    function automatic void write_setting(input logic [shp3_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [shp3_pkg::CFG_W-1:0] data);
        if (idx == shp3_pkg::CFG_FRAME_WIDTH) begin
            frame_w = data[shp3_pkg::FRAME_WIDTH_W-1:0];
            restart_stream();
        end else if (idx == shp3_pkg::CFG_FRAME_HEIGHT) begin
            frame_h = data[shp3_pkg::FRAME_HEIGHT_W-1:0];
            restart_stream();
        end
    endfunction

    function automatic void take_word(input logic cmd, input shp3_pkg::t_rgb px);
        int unsigned w, h, x, y, col;
        t_tap_set t;
        shp3_pkg::t_rgb up, mid;
        int k, r;
        w = active_width();
        h = active_height();
        if (cmd == shp3_pkg::CMD_DRAIN) begin
            // drains only count once the frame input is complete
            if (in_row < h || out_row >= h) return;
            if (out_row == h - 1) begin
                // last row: columns come straight from the line stores
                for (k = 0; k < 3; k++) begin
                    col = out_col + k;
                    col = (col == 0) ? 0 : col - 1;
                    if (col > w - 1) col = w - 1;
                    for (r = 0; r < 3; r++) begin
                        if (r == 0 && out_row != 0) t[r * 3 + k] = line_upper[col];
                        else t[r * 3 + k] = line_middle[col];
                    end
                end
            end else begin
                t = window_taps(w == 1 ? shp3_pkg::COL_RIGHT : shp3_pkg::COL_MID,
                                shp3_pkg::COL_RIGHT, shp3_pkg::COL_RIGHT, out_row == 0);
            end
            push_sharp(t, w, h);
            return;
        end

        if (in_row >= h) restart_stream();
        x = in_col;
        y = in_row;
        if (x >= w) x = w - 1;
        up  = line_upper[x];
        mid = line_middle[x];

        // first column of a row finishes the right edge of the row two above
        if (x == 0 && y >= 2) begin
            t = window_taps(w == 1 ? shp3_pkg::COL_RIGHT : shp3_pkg::COL_MID,
                            shp3_pkg::COL_RIGHT, shp3_pkg::COL_RIGHT, out_row == 0);
            push_sharp(t, w, h);
        end

        for (k = 0; k < 6; k++) win[k] = win[k + 3];
        win[6] = up;
        win[7] = mid;
        win[8] = px;
        line_upper[x]  = mid;
        line_middle[x] = px;

        if (x >= 1 && y >= 1) begin
            t = window_taps(x == 1 ? shp3_pkg::COL_MID : shp3_pkg::COL_LEFT,
                            shp3_pkg::COL_MID, shp3_pkg::COL_RIGHT, out_row == 0);
            push_sharp(t, w, h);
        end

        in_col = x + 1;
        if (in_col >= w) begin
            in_col = 0;
            in_row = y + 1;
        end
    endfunction

    always @(posedge i_clk) begin
        t_sharp_px want;
        if (!i_rst_n) begin
            clear_model();
        end else begin
            if (i_cfg_we) write_setting(i_cfg_index, i_cfg_data);
            if (i_in_valid && !i_in_stall) take_word(i_cmd, {i_red, i_green, i_blue});
            if (i_out_valid && !i_out_stall) begin
                if (sharp_q.size() == 0) begin
                    flag_error("result word with nothing expected");
                end else begin
                    want = sharp_q.pop_front();
                    o_checked++;
                    if (i_red_out !== want.red)
                        flag_error($sformatf("red_out %0h, want %0h", i_red_out, want.red));
                    if (i_green_out !== want.green)
                        flag_error($sformatf("green_out %0h, want %0h",
                                             i_green_out, want.green));
                    if (i_blue_out !== want.blue)
                        flag_error($sformatf("blue_out %0h, want %0h", i_blue_out, want.blue));
                    if (i_end_of_frame !== want.eof)
                        flag_error($sformatf("end_of_frame %0b, want %0b",
                                             i_end_of_frame, want.eof));
                end
            end
            if (i_done && !done_seen) begin
                done_seen = 1'b1;
                if (sharp_q.size() != 0)
                    flag_error($sformatf("%0d results never arrived", sharp_q.size()));
            end
        end
        o_pending = sharp_q.size();
    end

endmodule

/* verif/testbench.sv */
// top of the 3x3 rgb sharpen testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module testbench;

    import shp3_pkg::*;

    // indexes that map to no register
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    localparam int RANDOM_WORDS = 720;
    localparam int QUIET_AFTER  = 600;
    localparam int PAD_W        = CFG_W - FRAME_WIDTH_W;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    logic                 dut_stall;
    logic                 cmd       = CMD_PIXEL;
    logic [CHAN_W-1:0]    red       = '0;
    logic [CHAN_W-1:0]    green     = '0;
    logic [CHAN_W-1:0]    blue      = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [CHAN_W-1:0]    red_out, green_out, blue_out;
    logic                 end_of_frame;
    logic                 done      = 1'b0;

    int fail_count, pending, checked;
    int gap_pct     = 0;
    int stall_pct   = 0;
    bit quiet       = 1'b0;
    int stall_left  = 0;
    int words_sent  = 0;
    int settings    = 0;

    sharpen_3x3_rgb_unit DUT (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_valid        (in_valid),
        .o_stall        (dut_stall),
        .i_cmd          (cmd),
        .i_red          (red),
        .i_green        (green),
        .i_blue         (blue),
        .o_valid        (out_valid),
        .i_stall        (out_stall),
        .o_red_out      (red_out),
        .o_green_out    (green_out),
        .o_blue_out     (blue_out),
        .o_end_of_frame (end_of_frame)
    );

    sharpen_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .i_in_stall     (dut_stall),
        .i_cmd          (cmd),
        .i_red          (red),
        .i_green        (green),
        .i_blue         (blue),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_red_out      (red_out),
        .i_green_out    (green_out),
        .i_blue_out     (blue_out),
        .i_end_of_frame (end_of_frame),
        .i_done         (done),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver backpressure in bursts of random length
    always @(posedge clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end else if (!quiet && $urandom_range(99, 0) < stall_pct) begin
            stall_left <= $urandom_range(10, 0);
            out_stall  <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    task automatic send_word(input logic c, input logic [CHAN_W-1:0] r,
                             input logic [CHAN_W-1:0] g, input logic [CHAN_W-1:0] b);
        bit taken;
        if (!quiet && $urandom_range(99, 0) < gap_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(11, 1)) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        red      <= r;
        green    <= g;
        blue     <= b;
        // stall is read mid-cycle, once everything driven at the edge has settled
        do begin
            @(negedge clk);
            taken = !dut_stall;
            @(posedge clk);
        end while (!taken);
        words_sent++;
    endtask

    task automatic send_pixel(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                              input logic [CHAN_W-1:0] b);
        send_word(CMD_PIXEL, r, g, b);
    endtask

    // colour fields of a drain are don't-care, so they get noise
    task automatic send_drain();
        send_word(CMD_DRAIN, CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom));
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_frame(input logic [CFG_W-1:0] wdata, input logic [CFG_W-1:0] hdata);
        settle();
        write_reg(CFG_FRAME_WIDTH, wdata);
        write_reg(CFG_FRAME_HEIGHT, hdata);
        settings++;
    endtask

    function automatic int unsigned width_of(input logic [CFG_W-1:0] data);
        int unsigned v;
        v = 32'(data[FRAME_WIDTH_W-1:0]);
        if (v == 0) v = 1;
        if (v > DEF_MAX_WIDTH) v = DEF_MAX_WIDTH;
        return v;
    endfunction

    function automatic int unsigned height_of(input logic [CFG_W-1:0] data);
        return (data == '0) ? 1 : int'(data);
    endfunction

    // smooth frames keep the kernel inside 0..255, rough ones mostly clamp
    function automatic logic [CHAN_W-1:0] pick_chan(input bit smooth,
                                                    input logic [CHAN_W-1:0] base);
        logic [CHAN_W-1:0] v;
        v = CHAN_W'($urandom);
        if (smooth) v = base ^ CHAN_W'($urandom_range(3, 0));
        return v;
    endfunction

    task automatic stream_pixels(input int unsigned n, input bit noisy);
        bit smooth;
        logic [CHAN_W-1:0] br, bg, bb;
        int unsigned i;
        smooth = 1'($urandom_range(1, 0));
        br = CHAN_W'($urandom);
        bg = CHAN_W'($urandom);
        bb = CHAN_W'($urandom);
        for (i = 0; i < n; i++) begin
            if (noisy && $urandom_range(19, 0) == 0) send_drain();
            send_pixel(pick_chan(smooth, br), pick_chan(smooth, bg), pick_chan(smooth, bb));
        end
    endtask

    initial begin
        logic [CFG_W-1:0] wdata, hdata;
        int unsigned w, h, drains;
        int start_words, nfr, f;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset geometry of 640 wide: a part of the first row yields nothing
        gap_pct   = 10;
        stall_pct = 10;
        stream_pixels(20, 1'b1);

        // 3x3 frame of hard edges, with a drain before the frame is complete
        set_frame(16'd3, 16'd3);
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd0, 8'd255);
        send_pixel(8'd0, 8'd255, 8'd0);
        send_drain();
        send_pixel(8'd255, 8'd255, 8'd255);
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd128, 8'd1, 8'd254);
        send_pixel(8'd0, 8'd0, 8'd0);
        send_pixel(8'd255, 8'd255, 8'd255);
        // four pending, then two with nothing left
        repeat (6) send_drain();

        // writes to unused indexes mid-frame must not restart the stream
        stream_pixels(4, 1'b0);
        settle();
        write_reg(CFG_SPARE_LO, CFG_W'($urandom));
        write_reg(CFG_SPARE_HI, CFG_W'($urandom));
        stream_pixels(5, 1'b0);
        repeat (5) send_drain();

        // width 0 (upper bits masked off) and height 0 both act as 1
        set_frame(16'hF800, 16'd0);
        send_pixel(8'd255, 8'd0, 8'd128);
        send_drain();
        send_drain();
        // a new pixel drops the undrained one before it
        send_pixel(8'd7, 8'd200, 8'd33);
        send_pixel(8'd0, 8'd255, 8'd1);
        send_drain();

        set_frame(16'd1, 16'd5);
        stream_pixels(5, 1'b1);
        repeat (3) send_drain();

        set_frame(16'd5, 16'hFFFF);
        stream_pixels(23, 1'b1);

        // random geometry, frames back to back, broken drains now and then
        start_words = words_sent;
        while (words_sent - start_words < RANDOM_WORDS) begin
            if (words_sent - start_words >= QUIET_AFTER) quiet = 1'b1;
            case ($urandom_range(2, 0))
                0:       gap_pct = 0;
                1:       gap_pct = 10;
                default: gap_pct = 40;
            endcase
            case ($urandom_range(2, 0))
                0:       stall_pct = 0;
                1:       stall_pct = 10;
                default: stall_pct = 40;
            endcase
            case ($urandom_range(19, 0))
                0:       wdata = 16'd0;
                1, 2, 3: wdata = 16'($urandom_range(24, 9));
                default: wdata = 16'($urandom_range(8, 1));
            endcase
            if ($urandom_range(1, 0) == 1) wdata[CFG_W-1:FRAME_WIDTH_W] = PAD_W'($urandom);
            case ($urandom_range(9, 0))
                0:       hdata = 16'd0;
                1:       hdata = 16'($urandom_range(10, 6));
                default: hdata = 16'($urandom_range(5, 1));
            endcase
            set_frame(wdata, hdata);
            w   = width_of(wdata);
            h   = height_of(hdata);
            nfr = $urandom_range(3, 1);
            for (f = 0; f < nfr; f++) begin
                stream_pixels(w * h, 1'b1);
                if ($urandom_range(6, 0) == 0) drains = $urandom_range(w, 0);
                else drains = w + 1 + $urandom_range(2, 0);
                repeat (drains) send_drain();
            end
        end

        settle();
        done <= 1'b1;
        repeat (2) @(posedge clk);
        $display("covered %0d words over %0d frame geometries, %0d sharpened pixels compared",
                 words_sent, settings, checked);
        $display("geometry ran from 1x1 up to 24 wide, with masked and zero sizes");
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d results outstanding", pending);
        $display("TEST FAILED");
        $finish;
    end

endmodule
